[src/lidar_sector_min_steering_core_defines.svh]
// ----------------------------------------------------------------------------
// lidar_sector_min_steering_core_defines
// Assertion macros used by the checker file lsms_chk.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SECTOR_MIN_STEERING_CORE_DEFINES_SVH
`define LIDAR_SECTOR_MIN_STEERING_CORE_DEFINES_SVH

// same-cycle implication
`define LSMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/lsms_pkg.sv]
// ----------------------------------------------------------------------------
// lsms_pkg
// Types, constants and helpers for the lidar sector minimum steering core.
// ----------------------------------------------------------------------------
package lsms_pkg;

    localparam int RANGE_BITS   = 16;
    localparam int RANGE_IN_W   = 16;
    localparam int AVOID_W      = 16;
    localparam int CMP_W        = (RANGE_BITS > AVOID_W) ? RANGE_BITS : AVOID_W;
    localparam int START_W      = 18;
    localparam int STEP_W       = 12;
    localparam int CFG_W        = 18;
    localparam int CFG_IDX_W    = 2;
    localparam int ACC_W        = 24;
    localparam int NUM_SECTORS  = 12;
    localparam int SECT_W       = 4;
    localparam int SECTOR_SPAN  = 7680;
    localparam int FULL_TURN    = 92160;
    localparam int INF_RANGE_MM = 8000;
    localparam int FIRST_CHECK  = 5;
    localparam int MIDDLE_SECT  = 8;
    localparam int LAST_CHECK   = 11;
    localparam int DRIVE_STEP   = 10;
    localparam int DRIVE_W      = 8;
    localparam int DIST_W       = 2;
    localparam int ACC_MAX      = (1 << (ACC_W - 1)) - 1;

    localparam logic [RANGE_BITS-1:0] RANGE_MAX     = {RANGE_BITS{1'b1}};
    localparam logic [START_W-1:0]    START_RESET   = START_W'(-46080);
    localparam logic [STEP_W-1:0]     STEP_RESET    = STEP_W'(256);
    localparam logic [AVOID_W-1:0]    AVOID_RESET   = AVOID_W'(500);
    localparam logic [DRIVE_W-1:0]    BLOCKED_DRIVE = DRIVE_W'(-50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ANGLE = 2'd0,
        CFG_ANGLE_STEP  = 2'd1,
        CFG_AVOID_MM    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_WALK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic wr_start;
        logic wr_step;
        logic reload;
        logic advance;
    } t_acc_ctl;

    typedef struct packed {
        logic              in_range;
        logic [SECT_W-1:0] sector;
    } t_sector_info;

    function automatic logic [DRIVE_W-1:0] left_drive(input logic [SECT_W-1:0] sec);
        logic [DRIVE_W-1:0] q;
        q = DRIVE_W'(sec) - DRIVE_W'(FIRST_CHECK);
        return DRIVE_W'((q + DRIVE_W'(1)) * DRIVE_W'(DRIVE_STEP));
    endfunction

    function automatic logic [DRIVE_W-1:0] right_drive(input logic [SECT_W-1:0] sec);
        logic [DRIVE_W-1:0] q;
        q = DRIVE_W'(sec) - DRIVE_W'(FIRST_CHECK);
        return DRIVE_W'((DRIVE_W'(NUM_SECTORS / 2 + 1) - q) * DRIVE_W'(DRIVE_STEP));
    endfunction

endpackage

[src/lsms_ram.sv]
// ----------------------------------------------------------------------------
// lsms_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lsms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/lsms_angle.sv]
// ----------------------------------------------------------------------------
// lsms_angle
// Angle accumulator, start/step registers and sector mapping.
// ----------------------------------------------------------------------------
module lsms_angle (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsms_pkg::t_acc_ctl            i_ctl,
    input  logic [lsms_pkg::CFG_W-1:0]    i_cfg_data,
    output lsms_pkg::t_sector_info        o_info
);
    import lsms_pkg::*;

    logic signed [START_W-1:0] r_start;
    logic        [STEP_W-1:0]  r_step;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W:0]     n_sum;
    logic signed [ACC_W:0]     deg;
    logic        [SECT_W-1:0]  cnt;
    int                        k;

    localparam logic signed [ACC_W:0] ACC_MAX_X   = (ACC_W+1)'(ACC_MAX);
    localparam logic signed [ACC_W:0] FULL_TURN_X = (ACC_W+1)'(FULL_TURN);

    always_comb begin
        n_sum = $signed({r_acc[ACC_W-1], r_acc})
              + $signed({{(ACC_W+1-STEP_W){1'b0}}, r_step});
        n_acc = (n_sum > ACC_MAX_X) ? ACC_W'(ACC_MAX) : n_sum[ACC_W-1:0];

        deg = $signed({r_acc[ACC_W-1], r_acc});
        if (r_acc[ACC_W-1]) begin
            deg = deg + FULL_TURN_X;
        end

        cnt = '0;
        for (k = 1; k < NUM_SECTORS; k++) begin
            cnt = cnt + SECT_W'(deg >= $signed((ACC_W+1)'(k * SECTOR_SPAN)));
        end

        o_info.in_range = !deg[ACC_W] && (deg < FULL_TURN_X);
        o_info.sector   = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
            r_step  <= STEP_RESET;
            r_acc   <= ACC_W'($signed(START_RESET));
        end else begin
            if (i_ctl.wr_step) begin
                r_step <= i_cfg_data[STEP_W-1:0];
            end
            if (i_ctl.wr_start) begin
                r_start <= i_cfg_data[START_W-1:0];
                r_acc   <= ACC_W'($signed(i_cfg_data[START_W-1:0]));
            end else if (i_ctl.reload) begin
                r_acc   <= ACC_W'(r_start);
            end else if (i_ctl.advance) begin
                r_acc   <= n_acc;
            end
        end
    end

endmodule

[src/lidar_sector_min_steering_core.sv]
// ----------------------------------------------------------------------------
// lidar_sector_min_steering_core
// Per-sector minimum range tracking with scan-end steering decision.
// ----------------------------------------------------------------------------
// Use:
//   Samples enter on i_start while o_busy is low (one beat per accept edge).
//   Configuration writes go on i_cfg_valid/i_cfg_index/i_cfg_data; o_cfg_ready
//   is always high. The user must make writes while the core is idle; the
//   core does not enforce it. Each sample reads its sector minimum from the
//   sector RAM and writes back the new minimum; the core takes no new sample
//   until that read-modify-write is done.
//   On a last-of-scan sample the core then reads sectors 5..11 one per cycle
//   and publishes the decision: o_done pulses for one cycle with o_found,
//   o_chosen_sector and the drive values, when the core is idle again after
//   its update, walk and final states, all busy. It takes the next sample in
//   the cycle of the o_done beat. Results cannot be stalled.
//   Reset restores register defaults, reloads the angle and marks every
//   sector empty at once through per-sector valid bits (no clearing pass).
// ----------------------------------------------------------------------------
module lidar_sector_min_steering_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [lsms_pkg::RANGE_IN_W-1:0]       i_range_mm,
    input  logic                                  i_range_inf,
    input  logic                                  i_last_of_scan,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lsms_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lsms_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                  o_done,
    output logic                                  o_found,
    output logic [lsms_pkg::SECT_W-1:0]           o_chosen_sector,
    output logic signed [lsms_pkg::DRIVE_W-1:0]   o_left_drive,
    output logic signed [lsms_pkg::DRIVE_W-1:0]   o_right_drive
);
    import lsms_pkg::*;

    t_state              r_state, n_state;
    t_acc_ctl            acc_ctl;
    t_sector_info        info;

    logic [RANGE_BITS-1:0]  r_range;
    logic                   r_last;
    logic                   r_hit;
    logic [SECT_W-1:0]      r_sector;
    logic [SECT_W-1:0]      r_idx;
    logic                   r_chk_en;
    logic [SECT_W-1:0]      r_chk_idx;
    logic                   r_best_vld, n_best_vld;
    logic [DIST_W-1:0]      r_best_dist, n_best_dist;
    logic [SECT_W-1:0]      r_best_idx, n_best_idx;
    logic [NUM_SECTORS-1:0] r_valid;
    logic [AVOID_W-1:0]     r_avoid;
    logic                   r_done;
    logic                   r_found;
    logic [SECT_W-1:0]      r_chosen;
    logic [DRIVE_W-1:0]     r_left;
    logic [DRIVE_W-1:0]     r_right;

    logic                   accept;
    logic                   cfg_wr;
    logic [CMP_W-1:0]       in_range_w;
    logic [RANGE_BITS-1:0]  in_range_sat;
    logic [SECT_W-1:0]      ram_raddr;
    logic [RANGE_BITS-1:0]  ram_rdata;
    logic [RANGE_BITS-1:0]  cur_min;
    logic                   ram_we;
    logic [RANGE_BITS-1:0]  ram_wdata;
    logic                   open;
    logic [SECT_W-1:0]      dist_full;
    logic                   improve;

    assign accept      = i_start && (r_state == ST_IDLE);
    assign cfg_wr      = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != ST_IDLE);

    always_comb begin
        acc_ctl          = '0;
        acc_ctl.advance  = accept;
        acc_ctl.reload   = (r_state == ST_FIN);
        if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_ANGLE: acc_ctl.wr_start = 1'b1;
                CFG_ANGLE_STEP:  acc_ctl.wr_step  = 1'b1;
                default: ;
            endcase
        end
    end

    lsms_angle u_angle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (acc_ctl),
        .i_cfg_data (i_cfg_data),
        .o_info     (info)
    );

    lsms_ram #(
        .WIDTH (RANGE_BITS),
        .DEPTH (NUM_SECTORS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_sector),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        in_range_w   = i_range_inf ? CMP_W'(INF_RANGE_MM) : CMP_W'(i_range_mm);
        in_range_sat = (in_range_w > CMP_W'(RANGE_MAX)) ? RANGE_MAX
                                                        : in_range_w[RANGE_BITS-1:0];
    end

    // empty sectors read as all ones
    always_comb begin
        ram_raddr = (r_state == ST_WALK) ? r_idx : info.sector;
        cur_min   = r_valid[(r_state == ST_UPD) ? r_sector : r_chk_idx] ? ram_rdata
                                                                         : RANGE_MAX;
        ram_we    = (r_state == ST_UPD) && r_hit;
        ram_wdata = (r_range < cur_min) ? r_range : cur_min;
    end

    // nearest open sector to the middle, lower index wins a tie
    always_comb begin
        open      = CMP_W'(cur_min) >= CMP_W'(r_avoid);
        dist_full = (r_chk_idx >= SECT_W'(MIDDLE_SECT)) ? r_chk_idx - SECT_W'(MIDDLE_SECT)
                                                        : SECT_W'(MIDDLE_SECT) - r_chk_idx;
        improve   = r_chk_en && open
                 && (!r_best_vld || (dist_full[DIST_W-1:0] < r_best_dist));
        n_best_vld  = r_best_vld || improve;
        n_best_dist = improve ? dist_full[DIST_W-1:0] : r_best_dist;
        n_best_idx  = improve ? r_chk_idx : r_best_idx;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) begin
                n_state = ST_UPD;
            end
            ST_UPD:  n_state = r_last ? ST_WALK : ST_IDLE;
            ST_WALK: if (r_idx == SECT_W'(LAST_CHECK)) begin
                n_state = ST_FIN;
            end
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_avoid    <= AVOID_RESET;
            r_chk_en   <= 1'b0;
            r_best_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_FIN);
            if (cfg_wr && (t_cfg_idx'(i_cfg_index) == CFG_AVOID_MM)) begin
                r_avoid <= i_cfg_data[AVOID_W-1:0];
            end
            if (ram_we) begin
                r_valid[r_sector] <= 1'b1;
            end
            r_chk_en <= (r_state == ST_WALK);
            unique case (r_state)
                ST_UPD: begin
                    r_best_vld <= 1'b0;
                end
                ST_WALK: begin
                    r_best_vld <= n_best_vld;
                end
                ST_FIN: begin
                    r_valid <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_range  <= in_range_sat;
            r_last   <= i_last_of_scan;
            r_hit    <= info.in_range;
            r_sector <= info.sector;
        end
        if (r_state == ST_UPD) begin
            r_idx <= SECT_W'(FIRST_CHECK);
        end else if (r_state == ST_WALK) begin
            r_idx <= r_idx + SECT_W'(1);
        end
        r_chk_idx   <= r_idx;
        r_best_dist <= n_best_dist;
        r_best_idx  <= n_best_idx;
        if (r_state == ST_FIN) begin
            r_found  <= n_best_vld;
            r_chosen <= n_best_vld ? n_best_idx : '0;
            r_left   <= n_best_vld ? left_drive(n_best_idx)  : BLOCKED_DRIVE;
            r_right  <= n_best_vld ? right_drive(n_best_idx) : BLOCKED_DRIVE;
        end
    end

    assign o_done          = r_done;
    assign o_found         = r_found;
    assign o_chosen_sector = r_chosen;
    assign o_left_drive    = r_left;
    assign o_right_drive   = r_right;

endmodule

[src/lsms_chk.sv]
// ----------------------------------------------------------------------------
// lsms_chk
// Port-level checker for the lidar sector minimum steering core.
// ----------------------------------------------------------------------------
`include "lidar_sector_min_steering_core_defines.svh"

module lsms_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_start,
    input logic                                 o_busy,
    input logic                                 o_done,
    input logic                                 o_found,
    input logic [lsms_pkg::SECT_W-1:0]          o_chosen_sector,
    input logic signed [lsms_pkg::DRIVE_W-1:0]  o_left_drive,
    input logic signed [lsms_pkg::DRIVE_W-1:0]  o_right_drive
);
    import lsms_pkg::*;

    `LSMS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy && !o_done, "accepted beat did not make the core busy")
    `LSMS_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !o_busy, "result beat while busy")
    `LSMS_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result strobe longer than one cycle")
    `LSMS_ASSERT_SAME(a_blocked, i_clk, i_rst_n, o_done && !o_found, (o_chosen_sector == '0) && (o_left_drive == BLOCKED_DRIVE) && (o_right_drive == BLOCKED_DRIVE), "blocked result fields wrong")
    `LSMS_ASSERT_SAME(a_found, i_clk, i_rst_n, o_done && o_found, (o_chosen_sector >= SECT_W'(FIRST_CHECK)) && (o_chosen_sector <= SECT_W'(LAST_CHECK)) && (DRIVE_W'(o_left_drive + o_right_drive) == DRIVE_W'(80)), "found result fields wrong")

endmodule

bind lidar_sector_min_steering_core lsms_chk u_lsms_chk (.*);
